[design/sequence_gap_run_length_encoder_defines.svh]
// assertion macros for the gap-aware run-length encoder
// used by modules that check their own control logic; needs clk_i and rst_ni in scope
`ifndef SEQUENCE_GAP_RUN_LENGTH_ENCODER_DEFINES_SVH
`define SEQUENCE_GAP_RUN_LENGTH_ENCODER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SGRE_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define SGRE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/sgre_pkg.sv]
// shared types and constants of the gap-aware run-length encoder
// used by the front, command queue, back and top level; no dependencies
package sgre_pkg;

  // field widths
  localparam int CHAR_W  = 8;
  localparam int CODE_W  = 3;
  localparam int LEN_W   = 13;
  localparam int VALUE_W = 13;
  localparam int WIDTH_W = 4;
  localparam int COUNT_W = 32;

  // character codes and run limits
  localparam logic [CHAR_W-1:0] DOT_CHAR    = 8'd46;
  localparam logic [CHAR_W-1:0] HYPHEN_CHAR = 8'd45;
  localparam logic [LEN_W-1:0]  RUN_MAX     = 13'h1fff;
  localparam logic [LEN_W-1:0]  SHORT_MAX   = 13'd63;
  localparam logic [LEN_W-1:0]  MID_MAX     = 13'd1023;
  localparam logic [CODE_W-1:0] END_FLAG    = 3'h7;
  localparam logic [WIDTH_W-1:0] MAX_GROUP_WIDTH = 4'd13;

  // configuration registers
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CODE_W-1:0] DOT_CODE_RESET    = 3'd5;
  localparam logic [CODE_W-1:0] HYPHEN_CODE_RESET = 3'd6;

  typedef enum logic {
    REG_DOT_CODE    = 1'b0,
    REG_HYPHEN_CODE = 1'b1
  } cfg_reg_e;

  // command queue geometry
  localparam int QUEUE_AW    = 2;
  localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

  typedef enum logic [1:0] {
    RUN_NONE   = 2'd0,
    RUN_DOT    = 2'd1,
    RUN_HYPHEN = 2'd2
  } run_kind_e;

  // what follows the flushed run in one command
  typedef enum logic [1:0] {
    TAIL_NONE    = 2'd0,
    TAIL_SYMBOL  = 2'd1,
    TAIL_END     = 2'd2,
    TAIL_UNKNOWN = 2'd3
  } tail_e;

  // one classified item, expanded into groups by the back
  typedef struct packed {
    logic              has_run;
    logic [CODE_W-1:0] run_code;
    logic [LEN_W-1:0]  run_len;
    tail_e             tail;
    logic [CODE_W-1:0] tail_code;
    logic              valid_inc;
    logic              eos;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

[design/sgre_front.sv]
// front: accepts characters, tracks the open gap run and classifies each item
// depends on sgre_pkg; pushes commands into the command queue
module sgre_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [sgre_pkg::CHAR_W-1:0]  char_byte_i,
  input  logic                         is_valid_i,
  input  logic [sgre_pkg::CODE_W-1:0]  symbol_code_i,
  input  logic                         end_of_sequence_i,
  input  logic [sgre_pkg::CODE_W-1:0]  dot_code_i,
  input  logic [sgre_pkg::CODE_W-1:0]  hyphen_code_i,
  input  sgre_pkg::queue_status_t      queue_status_i,
  output logic                         push_o,
  output sgre_pkg::cmd_t               cmd_o
);

  sgre_pkg::run_kind_e             kind_q, kind_d;
  logic [sgre_pkg::LEN_W-1:0]      len_q, len_d;
  logic                            accept;
  logic                            run_open;
  sgre_pkg::run_kind_e             char_kind;
  logic                            is_run_char;

  assign in_stall_o = queue_status_i.full;
  assign accept     = in_valid_i && !queue_status_i.full;
  assign run_open   = (kind_q == sgre_pkg::RUN_DOT) || (kind_q == sgre_pkg::RUN_HYPHEN);

  // classify and build the command
  always_comb begin
    char_kind   = (char_byte_i == sgre_pkg::DOT_CHAR) ? sgre_pkg::RUN_DOT : sgre_pkg::RUN_HYPHEN;
    is_run_char = (char_byte_i == sgre_pkg::DOT_CHAR) || (char_byte_i == sgre_pkg::HYPHEN_CHAR);

    cmd_o.has_run   = run_open;
    cmd_o.run_code  = (kind_q == sgre_pkg::RUN_DOT) ? dot_code_i : hyphen_code_i;
    cmd_o.run_len   = len_q;
    cmd_o.tail      = sgre_pkg::TAIL_NONE;
    cmd_o.tail_code = hyphen_code_i;
    cmd_o.valid_inc = 1'b0;
    cmd_o.eos       = 1'b0;
    kind_d          = sgre_pkg::RUN_NONE;
    len_d           = '0;

    if (end_of_sequence_i) begin
      cmd_o.tail = sgre_pkg::TAIL_END;
      cmd_o.eos  = 1'b1;
    end else if (is_valid_i) begin
      cmd_o.tail      = sgre_pkg::TAIL_SYMBOL;
      cmd_o.tail_code = symbol_code_i;
      cmd_o.valid_inc = 1'b1;
    end else if (is_run_char) begin
      kind_d = char_kind;
      if (kind_q == char_kind) begin
        // same run: emit a full chunk only when the length is at its limit
        if (len_q == sgre_pkg::RUN_MAX) begin
          len_d = sgre_pkg::LEN_W'(1);
        end else begin
          cmd_o.has_run = 1'b0;
          len_d         = len_q + sgre_pkg::LEN_W'(1);
        end
      end else begin
        len_d = sgre_pkg::LEN_W'(1);
      end
    end else begin
      cmd_o.tail = sgre_pkg::TAIL_UNKNOWN;
    end
  end

  assign push_o = accept && (cmd_o.has_run || (cmd_o.tail != sgre_pkg::TAIL_NONE));

  // run state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= sgre_pkg::RUN_NONE;
      len_q  <= '0;
    end else if (accept) begin
      kind_q <= kind_d;
      len_q  <= len_d;
    end
  end

endmodule

[design/sgre_cmd_fifo.sv]
// short command queue between the front and the back
// depends on sgre_pkg for the command type and depth
module sgre_cmd_fifo (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  sgre_pkg::cmd_t           cmd_i,
  input  logic                     pop_i,
  output sgre_pkg::cmd_t           cmd_o,
  output sgre_pkg::queue_status_t  status_o
);

  sgre_pkg::cmd_t                  mem_q [sgre_pkg::QUEUE_DEPTH];
  logic [sgre_pkg::QUEUE_AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [sgre_pkg::QUEUE_AW:0]     count_q;
  logic                            do_push, do_pop;

  assign status_o.full  = (count_q == (sgre_pkg::QUEUE_AW+1)'(sgre_pkg::QUEUE_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign cmd_o   = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + sgre_pkg::QUEUE_AW'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + sgre_pkg::QUEUE_AW'(1);
      if (do_push && !do_pop) begin
        count_q <= count_q + (sgre_pkg::QUEUE_AW+1)'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - (sgre_pkg::QUEUE_AW+1)'(1);
      end
    end
  end

endmodule

[design/sgre_back.sv]
// back: expands commands into bit groups, one per cycle while not stalled
// keeps the totals; depends on sgre_pkg and the assertion macro header
`include "sequence_gap_run_length_encoder_defines.svh"

module sgre_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sgre_pkg::queue_status_t       queue_status_i,
  input  sgre_pkg::cmd_t                cmd_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [sgre_pkg::VALUE_W-1:0]  group_value_o,
  output logic [sgre_pkg::WIDTH_W-1:0]  group_width_o,
  output logic                          last_o,
  output logic                          sequence_done_o,
  output logic [sgre_pkg::COUNT_W-1:0]  total_bits_o,
  output logic [sgre_pkg::COUNT_W-1:0]  valid_total_o
);

  logic [2:0]                      idx_q, idx_d;
  logic [sgre_pkg::COUNT_W-1:0]    bc_q, vc_q;
  logic [sgre_pkg::COUNT_W-1:0]    vc_next, tb_next;
  logic [sgre_pkg::COUNT_W:0]      bit_sum;
  logic                            out_valid_q;
  logic [sgre_pkg::VALUE_W-1:0]    value_q, grp_value;
  logic [sgre_pkg::WIDTH_W-1:0]    width_q, grp_width;
  logic                            last_q, done_q, grp_last, grp_done;
  logic [sgre_pkg::COUNT_W-1:0]    tb_q, vt_q;
  logic [2:0]                      run_cnt, tail_cnt, total_cnt, tail_idx;
  logic                            load, seq_end;
  logic [sgre_pkg::LEN_W-1:0]      run_len;
  logic                            width_ok, totals_zero;

  // group decode for the current position in the head command
  always_comb begin
    run_len   = cmd_i.run_len;
    run_cnt   = !cmd_i.has_run ? 3'd0 : ((run_len <= sgre_pkg::LEN_W'(2)) ? 3'd2 : 3'd3);
    case (cmd_i.tail)
      sgre_pkg::TAIL_SYMBOL:  tail_cnt = 3'd1;
      sgre_pkg::TAIL_END:     tail_cnt = 3'd1;
      sgre_pkg::TAIL_UNKNOWN: tail_cnt = 3'd2;
      default:                tail_cnt = 3'd0;
    endcase
    total_cnt = run_cnt + tail_cnt;
    tail_idx  = idx_q - run_cnt;
    grp_value = '0;
    grp_width = 4'd1;
    grp_done  = 1'b0;

    if (idx_q < run_cnt) begin
      case (idx_q)
        3'd0: begin
          grp_value = sgre_pkg::VALUE_W'(cmd_i.run_code);
          grp_width = 4'd3;
        end
        3'd1: begin
          // length prefix
          if (run_len <= sgre_pkg::LEN_W'(1)) begin
            grp_value = sgre_pkg::VALUE_W'(1);
            grp_width = 4'd1;
          end else if (run_len == sgre_pkg::LEN_W'(2)) begin
            grp_value = sgre_pkg::VALUE_W'(1);
            grp_width = 4'd2;
          end else if (run_len <= sgre_pkg::SHORT_MAX) begin
            grp_value = sgre_pkg::VALUE_W'(1);
            grp_width = 4'd3;
          end else if (run_len <= sgre_pkg::MID_MAX) begin
            grp_value = sgre_pkg::VALUE_W'(1);
            grp_width = 4'd4;
          end else begin
            grp_value = '0;
            grp_width = 4'd4;
          end
        end
        default: begin
          // length field
          if (run_len <= sgre_pkg::SHORT_MAX) begin
            grp_value = sgre_pkg::VALUE_W'(run_len[5:0]);
            grp_width = 4'd6;
          end else if (run_len <= sgre_pkg::MID_MAX) begin
            grp_value = sgre_pkg::VALUE_W'(run_len[9:0]);
            grp_width = 4'd10;
          end else begin
            grp_value = run_len;
            grp_width = 4'd13;
          end
        end
      endcase
    end else begin
      case (cmd_i.tail)
        sgre_pkg::TAIL_SYMBOL: begin
          grp_value = sgre_pkg::VALUE_W'(cmd_i.tail_code);
          grp_width = 4'd3;
        end
        sgre_pkg::TAIL_END: begin
          grp_value = sgre_pkg::VALUE_W'(sgre_pkg::END_FLAG);
          grp_width = 4'd3;
          grp_done  = 1'b1;
        end
        sgre_pkg::TAIL_UNKNOWN: begin
          // unknown character is a hyphen run of length one
          if (tail_idx == 3'd0) begin
            grp_value = sgre_pkg::VALUE_W'(cmd_i.tail_code);
            grp_width = 4'd3;
          end else begin
            grp_value = sgre_pkg::VALUE_W'(1);
            grp_width = 4'd1;
          end
        end
        default: begin
          grp_value = '0;
          grp_width = 4'd1;
        end
      endcase
    end
    grp_last = (idx_q == total_cnt - 3'd1);
  end

  // handshake and counters
  assign load    = !queue_status_i.empty && (!out_valid_q || !out_stall_i);
  assign pop_o   = load && grp_last;
  assign seq_end = cmd_i.eos && grp_last;
  assign idx_d   = !load ? idx_q : (grp_last ? 3'd0 : idx_q + 3'd1);

  always_comb begin
    vc_next = vc_q;
    if (cmd_i.valid_inc && (idx_q == 3'd0) && (vc_q != '1)) begin
      vc_next = vc_q + sgre_pkg::COUNT_W'(1);
    end
    bit_sum = {1'b0, bc_q} + (sgre_pkg::COUNT_W+1)'(grp_width);
    tb_next = bit_sum[sgre_pkg::COUNT_W] ? '1 : bit_sum[sgre_pkg::COUNT_W-1:0];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      bc_q        <= '0;
      vc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (load) begin
        bc_q        <= seq_end ? '0 : tb_next;
        vc_q        <= seq_end ? '0 : vc_next;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output word register
  always_ff @(posedge clk_i) begin
    if (load) begin
      value_q <= grp_value;
      width_q <= grp_width;
      last_q  <= grp_last;
      done_q  <= grp_done;
      tb_q    <= tb_next;
      vt_q    <= vc_next;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign group_value_o   = value_q;
  assign group_width_o   = width_q;
  assign last_o          = last_q;
  assign sequence_done_o = done_q;
  assign total_bits_o    = tb_q;
  assign valid_total_o   = vt_q;

  // terms for the checks below
  assign width_ok    = (width_q != '0) && (width_q <= sgre_pkg::MAX_GROUP_WIDTH);
  assign totals_zero = (bc_q == '0) && (vc_q == '0);

  `SGRE_ASSERT(a_done_is_last, out_valid_q && done_q, last_q, "end flag word not last")
  `SGRE_ASSERT(a_width_range, out_valid_q, width_ok, "group width out of range")
  `SGRE_ASSERT_NEXT(a_totals_cleared, load && seq_end, totals_zero, "totals not cleared")
  `SGRE_ASSERT(a_pop_on_last, pop_o, !queue_status_i.empty && (idx_q < 3'd5), "bad pop")

endmodule

[design/sequence_gap_run_length_encoder.sv]
// an accepted word's groups pass the command queue and the output register
// throughput: one input word per cycle while the four-entry command queue has room
// the back emits one group per cycle while not stalled; an item gives zero to five groups
// reset: asynchronous active low; clears run state, totals, queue and output valid
// configuration codes return to dot 5 and hyphen 6
module sequence_gap_run_length_encoder (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [sgre_pkg::CHAR_W-1:0]         char_byte_i,
  input  logic                                is_valid_i,
  input  logic [sgre_pkg::CODE_W-1:0]         symbol_code_i,
  input  logic                                end_of_sequence_i,
  // output channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [sgre_pkg::VALUE_W-1:0]        group_value_o,
  output logic [sgre_pkg::WIDTH_W-1:0]        group_width_o,
  output logic                                last_o,
  output logic                                sequence_done_o,
  output logic [sgre_pkg::COUNT_W-1:0]        total_bits_o,
  output logic [sgre_pkg::COUNT_W-1:0]        valid_total_o,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sgre_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [sgre_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [sgre_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);

  logic [sgre_pkg::CODE_W-1:0]  dot_code_q, hyphen_code_q;
  logic                         cfg_write;
  sgre_pkg::cfg_reg_e           cfg_sel;
  sgre_pkg::queue_status_t      queue_status;
  sgre_pkg::cmd_t               push_cmd, head_cmd;
  logic                         push, pop;

  // configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_sel   = sgre_pkg::cfg_reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_code_q    <= sgre_pkg::DOT_CODE_RESET;
      hyphen_code_q <= sgre_pkg::HYPHEN_CODE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_sel)
        sgre_pkg::REG_DOT_CODE:    dot_code_q    <= pwdata[sgre_pkg::CODE_W-1:0];
        sgre_pkg::REG_HYPHEN_CODE: hyphen_code_q <= pwdata[sgre_pkg::CODE_W-1:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (cfg_sel)
      sgre_pkg::REG_DOT_CODE:    prdata = sgre_pkg::CFG_DATA_W'(dot_code_q);
      sgre_pkg::REG_HYPHEN_CODE: prdata = sgre_pkg::CFG_DATA_W'(hyphen_code_q);
      default:                   prdata = '0;
    endcase
  end

  sgre_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .char_byte_i       (char_byte_i),
    .is_valid_i        (is_valid_i),
    .symbol_code_i     (symbol_code_i),
    .end_of_sequence_i (end_of_sequence_i),
    .dot_code_i        (dot_code_q),
    .hyphen_code_i     (hyphen_code_q),
    .queue_status_i    (queue_status),
    .push_o            (push),
    .cmd_o             (push_cmd)
  );

  sgre_cmd_fifo u_cmd_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .cmd_i    (push_cmd),
    .pop_i    (pop),
    .cmd_o    (head_cmd),
    .status_o (queue_status)
  );

  sgre_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .queue_status_i  (queue_status),
    .cmd_i           (head_cmd),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .group_value_o   (group_value_o),
    .group_width_o   (group_width_o),
    .last_o          (last_o),
    .sequence_done_o (sequence_done_o),
    .total_bits_o    (total_bits_o),
    .valid_total_o   (valid_total_o)
  );

endmodule
